FILE: hw/rtl/ckhq_pkg.sv
// Package for the composite-key heap queue: widths, codes, state enum.
// No dependencies.
`timescale 1ns / 1ps
package ckhq_pkg;
    localparam int CAPACITY_DEF = 64;
    localparam int KEY_W  = 58;
    localparam int TAG_W  = 16;
    localparam int ENT_W  = KEY_W + TAG_W;
    localparam int SH_CLASS = 55;
    localparam int SH_YEAR  = 41;
    localparam int SH_MONTH = 37;
    localparam int SH_DAY   = 32;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_DN_WAITR,
        S_TOP_RD,
        S_TOP_WAIT,
        S_OUT
    } t_state;
endpackage

FILE: hw/rtl/ckhq_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module ckhq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: hw/rtl/composite_key_max_heap_queue.sv
// Top level of the composite-key max-heap queue: sequencer, entry RAM, output word.
// Depends on ckhq_pkg and ckhq_ram.
//
//  channel | signals                        | dir
//  in      | i_valid/o_ready, i_func..i_tag | word in
//  out     | o_valid/i_ready, o_status..    | word out
//
// A query or a dropped word passes through accept, top read, top wait and output.
// An insert adds a parent read and a compare for each level climbed, then places
// the entry; a remove first reads the last entry, then adds a left read, a right
// read and a compare for each level descended. The single RAM port allows one access per cycle.
// Reset empties the queue and clears the arrival counter; RAM is not cleared.
// A held result waits in the output register; input stalls until it is taken.
`timescale 1ns / 1ps
module composite_key_max_heap_queue #(
    parameter int CAPACITY = ckhq_pkg::CAPACITY_DEF,
    parameter int CW = $clog2(CAPACITY + 1),
    parameter int AW = $clog2(CAPACITY)
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_func,
    input  logic [2:0]  i_sender_class,
    input  logic [13:0] i_year,
    input  logic [3:0]  i_month,
    input  logic [4:0]  i_day,
    input  logic [15:0] i_tag,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [CW-1:0] o_entry_count,
    output logic        o_top_valid,
    output logic [2:0]  o_top_class,
    output logic [13:0] o_top_year,
    output logic [3:0]  o_top_month,
    output logic [4:0]  o_top_day,
    output logic [15:0] o_top_tag
);
    localparam int EW = ckhq_pkg::ENT_W;
    localparam int KW = ckhq_pkg::KEY_W;

    ckhq_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [31:0]   r_arrival, n_arrival;
    logic [CW-1:0] r_pos, n_pos;       // current slot being sifted
    logic [CW-1:0] r_best, n_best;     // best child slot
    logic [EW-1:0] r_cur, n_cur;       // entry being moved
    logic [EW-1:0] r_cand, n_cand;     // left child entry, held for the compare
    logic [1:0]    r_status, n_status;

    // memory port
    logic          m_we;
    logic [AW-1:0] m_addr;
    logic [EW-1:0] m_wdata, m_rdata;

    ckhq_ram #(.WIDTH(EW), .DEPTH(CAPACITY), .AW(AW)) u_ram (
        .i_clk(i_clk), .i_we(m_we), .i_addr(m_addr),
        .i_wdata(m_wdata), .o_rdata(m_rdata)
    );

    logic [2:0]  w_cls;
    logic [CW-1:0] w_parent;
    logic [CW:0] w_left, w_right, w_count;  // one bit wider so child slots never wrap
    logic w_acc;

    assign w_acc = i_valid && o_ready;
    assign w_cls = (i_sender_class < 3'd1 || i_sender_class > 3'd5) ? 3'd1 : i_sender_class;
    assign w_parent = (r_pos - CW'(1)) >> 1;
    assign w_left   = {r_pos, 1'b1};
    assign w_right  = w_left + (CW+1)'(1);
    assign w_count  = {1'b0, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ckhq_pkg::S_IDLE;
            r_count   <= '0;
            r_arrival <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_arrival <= n_arrival;
        end
        r_pos    <= n_pos;
        r_best   <= n_best;
        r_cur    <= n_cur;
        r_cand   <= n_cand;
        r_status <= n_status;
    end

    // next state and datapath
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_arrival = r_arrival;
        n_pos     = r_pos;
        n_best    = r_best;
        n_cur     = r_cur;
        n_cand    = r_cand;
        n_status  = r_status;
        unique case (r_state)
            ckhq_pkg::S_IDLE: begin
                if (w_acc) begin
                    n_status = ckhq_pkg::ST_OK;
                    n_state  = ckhq_pkg::S_TOP_RD;
                    if (i_func == ckhq_pkg::FUNC_INSERT) begin
                        if (r_count >= CW'(CAPACITY)) begin
                            n_status = ckhq_pkg::ST_FULL;
                        end else begin
                            n_cur = {w_cls, i_year, i_month, i_day, r_arrival, i_tag};
                            n_arrival = r_arrival + 32'd1;
                            n_pos   = r_count;
                            n_count = r_count + CW'(1);
                            n_state = ckhq_pkg::S_UP_RD;
                        end
                    end else if (i_func == ckhq_pkg::FUNC_REMOVE) begin
                        if (r_count == '0) begin
                            n_status = ckhq_pkg::ST_EMPTY;
                        end else begin
                            // read last entry; it moves to the root
                            n_count = r_count - CW'(1);
                            n_pos   = '0;
                            n_state = ckhq_pkg::S_DN_WAITR;
                        end
                    end
                end
            end
            ckhq_pkg::S_UP_RD: begin
                // read parent, or place at root
                if (r_pos == '0) n_state = ckhq_pkg::S_TOP_RD;
                else n_state = ckhq_pkg::S_UP_CMP;
            end
            ckhq_pkg::S_UP_CMP: begin
                // read data for parent is valid now
                if (r_cur[EW-1 -: KW] > m_rdata[EW-1 -: KW]) begin
                    n_pos   = w_parent;
                    n_state = ckhq_pkg::S_UP_RD;
                end else begin
                    n_state = ckhq_pkg::S_TOP_RD;
                end
            end
            ckhq_pkg::S_DN_WAITR: begin
                n_cur = m_rdata;
                n_state = ckhq_pkg::S_DN_RDL;
            end
            ckhq_pkg::S_DN_RDL: begin
                if (w_left >= w_count) n_state = ckhq_pkg::S_TOP_RD;
                else n_state = ckhq_pkg::S_DN_RDR;
            end
            ckhq_pkg::S_DN_RDR: begin
                n_cand = m_rdata;
                n_best = w_left[CW-1:0];
                n_state = (w_right < w_count) ? ckhq_pkg::S_DN_CMP : ckhq_pkg::S_DN_WAITR;
                if (w_right >= w_count) begin
                    // single child: decide now
                    n_state = ckhq_pkg::S_TOP_RD;
                    if (m_rdata[EW-1 -: KW] > r_cur[EW-1 -: KW]) begin
                        n_pos = w_left[CW-1:0];
                        n_state = ckhq_pkg::S_DN_RDL;
                    end
                end
            end
            ckhq_pkg::S_DN_CMP: begin
                n_state = ckhq_pkg::S_TOP_RD;
                if (m_rdata[EW-1 -: KW] > r_cand[EW-1 -: KW]) begin
                    if (m_rdata[EW-1 -: KW] > r_cur[EW-1 -: KW]) begin
                        n_pos = w_right[CW-1:0];
                        n_state = ckhq_pkg::S_DN_RDL;
                    end
                end else if (r_cand[EW-1 -: KW] > r_cur[EW-1 -: KW]) begin
                    n_pos = r_best;
                    n_state = ckhq_pkg::S_DN_RDL;
                end
            end
            ckhq_pkg::S_TOP_RD:   n_state = ckhq_pkg::S_TOP_WAIT;
            ckhq_pkg::S_TOP_WAIT: n_state = ckhq_pkg::S_OUT;
            ckhq_pkg::S_OUT: begin
                if (i_ready) n_state = ckhq_pkg::S_IDLE;
            end
            default: n_state = ckhq_pkg::S_IDLE;
        endcase
    end

    // memory port control; a swap writes the parent or child that trades places with cur at the slot being left
    always_comb begin
        m_we    = 1'b0;
        m_addr  = r_pos[AW-1:0];
        m_wdata = r_cur;
        unique case (r_state)
            ckhq_pkg::S_IDLE: m_addr = AW'(r_count - CW'(1));
            ckhq_pkg::S_UP_RD: begin
                if (r_pos == '0) m_we = 1'b1;
                else m_addr = w_parent[AW-1:0];
            end
            ckhq_pkg::S_UP_CMP: begin
                // parent moves down into r_pos, or cur settles in r_pos
                m_we = 1'b1;
                if (r_cur[EW-1 -: KW] > m_rdata[EW-1 -: KW]) m_wdata = m_rdata;
            end
            ckhq_pkg::S_DN_RDL: begin
                if (w_left >= w_count) m_we = 1'b1;
                else m_addr = w_left[AW-1:0];
            end
            ckhq_pkg::S_DN_RDR: begin
                if (w_right < w_count) begin
                    m_addr = w_right[AW-1:0];
                end else begin
                    m_we = 1'b1;
                    if (m_rdata[EW-1 -: KW] > r_cur[EW-1 -: KW]) m_wdata = m_rdata;
                end
            end
            ckhq_pkg::S_DN_CMP: begin
                m_we = 1'b1;
                if (m_rdata[EW-1 -: KW] > r_cand[EW-1 -: KW]) begin
                    if (m_rdata[EW-1 -: KW] > r_cur[EW-1 -: KW]) m_wdata = m_rdata;
                end else if (r_cand[EW-1 -: KW] > r_cur[EW-1 -: KW]) begin
                    m_wdata = r_cand;
                end
            end
            ckhq_pkg::S_TOP_RD: m_addr = '0;
            default: ;
        endcase
    end

    // output word, held until taken
    logic [EW-1:0] r_top;
    always_ff @(posedge i_clk) begin
        if (r_state == ckhq_pkg::S_TOP_WAIT) r_top <= m_rdata;
    end

    logic w_ne;
    assign w_ne = (r_count != '0);
    always_comb begin
        o_ready       = (r_state == ckhq_pkg::S_IDLE);
        o_valid       = (r_state == ckhq_pkg::S_OUT);
        o_status      = r_status;
        o_entry_count = r_count;
        o_top_valid   = w_ne;
        o_top_class   = w_ne ? r_top[EW-1 -: 3] : '0;
        o_top_year    = w_ne ? r_top[EW-4 -: 14] : '0;
        o_top_month   = w_ne ? r_top[EW-18 -: 4] : '0;
        o_top_day     = w_ne ? r_top[EW-22 -: 5] : '0;
        o_top_tag     = w_ne ? r_top[15:0] : '0;
    end

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY)) else $error("count above capacity");
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ckhq_pkg::ST_FULL) |-> o_entry_count == CW'(CAPACITY))
        else $error("full status with room");
    a_empty_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ckhq_pkg::ST_EMPTY) |-> !o_top_valid)
        else $error("empty status with entries");
`endif
endmodule

FILE: dv/composite_key_max_heap_queue_test.sv
// Self-checking bench for composite_key_max_heap_queue: insert, remove and query words.
// Depends on ckhq_pkg and the block RTL; a behavioral heap predicts every result.
`timescale 1ns / 1ps
module composite_key_max_heap_queue_test;
    localparam int CAP = 64;
    localparam logic [1:0] FUNC_QUERY = 2'd2;
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [2:0]  sender_class;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [15:0] tag;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  entry_count;
        logic        top_valid;
        logic [2:0]  top_class;
        logic [13:0] top_year;
        logic [3:0]  top_month;
        logic [4:0]  top_day;
        logic [15:0] top_tag;
    } t_top;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_func = '0;
    logic [2:0]  i_sender_class = '0;
    logic [13:0] i_year = '0;
    logic [3:0]  i_month = '0;
    logic [4:0]  i_day = '0;
    logic [15:0] i_tag = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic [6:0]  o_entry_count;
    logic        o_top_valid;
    logic [2:0]  o_top_class;
    logic [13:0] o_top_year;
    logic [3:0]  o_top_month;
    logic [4:0]  o_top_day;
    logic [15:0] o_top_tag;

    composite_key_max_heap_queue #(.CAPACITY(CAP)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_func(i_func), .i_sender_class(i_sender_class), .i_year(i_year),
        .i_month(i_month), .i_day(i_day), .i_tag(i_tag),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_status(o_status), .o_entry_count(o_entry_count),
        .o_top_valid(o_top_valid), .o_top_class(o_top_class),
        .o_top_year(o_top_year), .o_top_month(o_top_month),
        .o_top_day(o_top_day), .o_top_tag(o_top_tag)
    );

    always #6 i_clk = ~i_clk;

    // Predictor state: keys hold class|year|month|day|arrival, tags beside them.
    logic [57:0] model_keys [CAP];
    logic [15:0] model_tags [CAP];
    int unsigned model_count = 0;
    logic [31:0] model_arrival = '0;

    t_cmd pending_words [$];
    t_top expected_tops [$];
    int   error_count = 0;
    bit   calm_mode = 1'b0;    // no idling in the final stretch
    int   rx_hold = 0;         // long receiver hold-off, in cycles
    bit   tx_pause = 1'b0;     // sender waits for an empty scoreboard

    function automatic void swap_slot(int unsigned a, int unsigned b);
        logic [57:0] k;
        logic [15:0] t;
        k = model_keys[a]; t = model_tags[a];
        model_keys[a] = model_keys[b]; model_tags[a] = model_tags[b];
        model_keys[b] = k; model_tags[b] = t;
    endfunction

    function automatic t_top predict_top(t_cmd c);
        t_top r;
        int unsigned pos, up, l, rt, best;
        logic [2:0] cls;
        r = '0;
        if (c.func == ckhq_pkg::FUNC_INSERT) begin
            if (model_count >= CAP) begin
                r.status = ckhq_pkg::ST_FULL;
            end else begin
                cls = (c.sender_class < 1 || c.sender_class > 5) ? 3'd1 : c.sender_class;
                model_keys[model_count] = {cls, c.year, c.month, c.day, model_arrival};
                model_tags[model_count] = c.tag;
                model_arrival = model_arrival + 1;
                pos = model_count;
                model_count++;
                while (pos > 0) begin
                    up = (pos - 1) / 2;
                    if (model_keys[pos] > model_keys[up]) begin
                        swap_slot(pos, up);
                        pos = up;
                    end else begin
                        break;
                    end
                end
            end
        end else if (c.func == ckhq_pkg::FUNC_REMOVE) begin
            if (model_count == 0) begin
                r.status = ckhq_pkg::ST_EMPTY;
            end else begin
                model_count--;
                model_keys[0] = model_keys[model_count];
                model_tags[0] = model_tags[model_count];
                pos = 0;
                forever begin
                    l = 2 * pos + 1; rt = 2 * pos + 2; best = pos;
                    if (l < model_count && model_keys[l] > model_keys[best]) best = l;
                    if (rt < model_count && model_keys[rt] > model_keys[best]) best = rt;
                    if (best == pos) break;
                    swap_slot(pos, best);
                    pos = best;
                end
            end
        end
        r.entry_count = model_count[6:0];
        if (model_count > 0) begin
            r.top_valid = 1'b1;
            r.top_class = 3'(model_keys[0] >> ckhq_pkg::SH_CLASS);
            r.top_year  = 14'(model_keys[0] >> ckhq_pkg::SH_YEAR);
            r.top_month = 4'(model_keys[0] >> ckhq_pkg::SH_MONTH);
            r.top_day   = 5'(model_keys[0] >> ckhq_pkg::SH_DAY);
            r.top_tag   = model_tags[0];
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic t_cmd rand_cmd(logic [1:0] f);
        t_cmd c;
        c.func = f;
        c.sender_class = $urandom_range(0, 9) == 0 ? 3'($urandom) : 3'($urandom_range(1, 5));
        // Few distinct dates so ties fall through to the arrival number.
        c.year  = $urandom_range(0, 3) == 0 ? 14'($urandom) : 14'(2020 + $urandom_range(0, 2));
        c.month = $urandom_range(0, 5) == 0 ? 4'($urandom) : 4'($urandom_range(1, 2));
        c.day   = $urandom_range(0, 5) == 0 ? 5'($urandom) : 5'($urandom_range(1, 2));
        c.tag   = 16'($urandom);
        return c;
    endfunction

    function automatic t_cmd make_cmd(logic [1:0] f, logic [2:0] s, logic [13:0] y,
                                      logic [3:0] m, logic [4:0] d, logic [15:0] t);
        t_cmd c;
        c = '{func: f, sender_class: s, year: y, month: m, day: d, tag: t};
        return c;
    endfunction

    // Driver: advance to the next word once the current one is taken.
    int tx_gap = 0;
    always @(posedge i_clk) begin
        t_cmd c;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                expected_tops.push_back(predict_top({i_func, i_sender_class, i_year,
                                                     i_month, i_day, i_tag}));
            end
            if (!i_valid || o_ready) begin
                if (tx_gap > 0) begin
                    tx_gap <= tx_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_words.size() > 0 && !tx_pause &&
                             !(i_valid && o_ready && pending_words.size() == 0)) begin
                    if (!calm_mode && $urandom_range(0, 7) == 0) begin
                        tx_gap <= $urandom_range(0, 2);
                        i_valid <= 1'b0;
                    end else begin
                        c = pending_words.pop_front();
                        i_valid <= 1'b1;
                        i_func <= c.func; i_sender_class <= c.sender_class;
                        i_year <= c.year; i_month <= c.month;
                        i_day <= c.day; i_tag <= c.tag;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each taken result with the oldest prediction.
    int rx_gap = 0;
    always @(posedge i_clk) begin
        t_top w;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_tops.size() == 0) begin
                    report_mismatch("unexpected word", 0, 0);
                end else begin
                    w = expected_tops.pop_front();
                    if (o_status !== w.status) report_mismatch("status", o_status, w.status);
                    if (o_entry_count !== w.entry_count)
                        report_mismatch("entry_count", o_entry_count, w.entry_count);
                    if (o_top_valid !== w.top_valid)
                        report_mismatch("top_valid", o_top_valid, w.top_valid);
                    if (o_top_class !== w.top_class)
                        report_mismatch("top_class", o_top_class, w.top_class);
                    if (o_top_year !== w.top_year)
                        report_mismatch("top_year", o_top_year, w.top_year);
                    if (o_top_month !== w.top_month)
                        report_mismatch("top_month", o_top_month, w.top_month);
                    if (o_top_day !== w.top_day) report_mismatch("top_day", o_top_day, w.top_day);
                    if (o_top_tag !== w.top_tag) report_mismatch("top_tag", o_top_tag, w.top_tag);
                end
            end
            if (rx_hold > 0) begin
                rx_hold <= rx_hold - 1;
                i_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                i_ready <= 1'b0;
            end else if (!calm_mode && $urandom_range(0, 7) == 0) begin
                rx_gap <= $urandom_range(0, 2);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic wait_drained();
        while (pending_words.size() > 0 || i_valid || expected_tops.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        int n;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty remove, field extremes, bad class, spare code, ties.
        pending_words.push_back(make_cmd(ckhq_pkg::FUNC_REMOVE, 3'd0, 14'd0, 4'd0, 5'd0, 16'd0));
        pending_words.push_back(make_cmd(FUNC_QUERY, 3'd7, 14'h3fff, 4'hf, 5'h1f, 16'hffff));
        pending_words.push_back(make_cmd(FUNC_SPARE, 3'd5, 14'd9999, 4'd12, 5'd31, 16'h1234));
        pending_words.push_back(make_cmd(ckhq_pkg::FUNC_INSERT, 3'd1, 14'd0, 4'd1, 5'd1,
                                         16'h0000));
        pending_words.push_back(make_cmd(ckhq_pkg::FUNC_INSERT, 3'd5, 14'd9999, 4'd12, 5'd31,
                                         16'hffff));
        pending_words.push_back(make_cmd(ckhq_pkg::FUNC_INSERT, 3'd0, 14'h3fff, 4'hf, 5'h1f,
                                         16'h00aa));
        pending_words.push_back(make_cmd(ckhq_pkg::FUNC_INSERT, 3'd7, 14'd5, 4'd5, 5'd5,
                                         16'h5555));
        pending_words.push_back(make_cmd(ckhq_pkg::FUNC_INSERT, 3'd6, 14'd5, 4'd5, 5'd5,
                                         16'haaaa));
        pending_words.push_back(make_cmd(ckhq_pkg::FUNC_INSERT, 3'd5, 14'd9999, 4'd12, 5'd31,
                                         16'h0f0f));
        pending_words.push_back(make_cmd(ckhq_pkg::FUNC_INSERT, 3'd3, 14'd2000, 4'd0, 5'd0,
                                         16'hf0f0));
        pending_words.push_back(make_cmd(ckhq_pkg::FUNC_INSERT, 3'd3, 14'd1999, 4'd12, 5'd31,
                                         16'h3c3c));
        pending_words.push_back(make_cmd(ckhq_pkg::FUNC_INSERT, 3'd3, 14'd2000, 4'd0, 5'd1,
                                         16'hc3c3));
        for (int i = 0; i < 8; i++)
            pending_words.push_back(make_cmd(ckhq_pkg::FUNC_REMOVE, 3'd0, 14'd0, 4'd0, 5'd0,
                                             16'd0));
        pending_words.push_back(make_cmd(FUNC_QUERY, 3'd0, 14'd0, 4'd0, 5'd0, 16'd0));
        wait_drained();

        // Fill past capacity while the receiver holds off, then drain to empty.
        rx_hold <= 300;
        for (int i = 0; i < CAP + 4; i++)
            pending_words.push_back(rand_cmd(ckhq_pkg::FUNC_INSERT));
        for (int i = 0; i < 3; i++) pending_words.push_back(rand_cmd(FUNC_QUERY));
        for (int i = 0; i < CAP + 2; i++)
            pending_words.push_back(rand_cmd(ckhq_pkg::FUNC_REMOVE));
        wait_drained();

        // Random phases that alternate between insert-heavy and remove-heavy mixes.
        for (int phase = 0; phase < 6; phase++) begin
            for (int i = 0; i < 80; i++) begin
                n = $urandom_range(0, 99);
                if (phase % 2 == 0)
                    pending_words.push_back(rand_cmd(n < 60 ? ckhq_pkg::FUNC_INSERT :
                                            n < 90 ? ckhq_pkg::FUNC_REMOVE :
                                            2'($urandom_range(2, 3))));
                else
                    pending_words.push_back(rand_cmd(n < 35 ? ckhq_pkg::FUNC_INSERT :
                                            n < 90 ? ckhq_pkg::FUNC_REMOVE :
                                            2'($urandom_range(2, 3))));
            end
            if (phase == 2) begin
                // Hold the sender until every result has come back.
                while (pending_words.size() > 0 || i_valid) @(posedge i_clk);
                tx_pause = 1'b1;
                while (expected_tops.size() > 0) @(posedge i_clk);
                tx_pause = 1'b0;
            end
        end
        while (pending_words.size() > 0) @(posedge i_clk);

        calm_mode = 1'b1;
        for (int i = 0; i < 40; i++)
            pending_words.push_back(rand_cmd($urandom_range(0, 1) ? ckhq_pkg::FUNC_INSERT :
                                             ckhq_pkg::FUNC_REMOVE));
        wait_drained();
        repeat (60) @(posedge i_clk);

        if (error_count == 0)
            $display("composite_key_max_heap_queue_test: PASS");
        else
            $display("composite_key_max_heap_queue_test: FAIL");
        $finish;
    end

    initial begin
        #5ms;
        $display("composite_key_max_heap_queue_test: FAIL");
        $finish;
    end
endmodule
